// ----- rtl/core/tccl_pkg.sv -----
// Package for the temperature/current charge lookup.
// Holds parameter defaults, command and register index codes and the
// divide-by-255 fold step type. No dependencies.
package tccl_pkg;

  localparam int unsigned ROW_MAX_DEF = 16;
  localparam int unsigned COL_MAX_DEF = 16;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned MAG_W       = 32;   // magnitude of a 33-bit difference
  localparam int unsigned NUM_W       = 37;   // count * magnitude
  localparam int unsigned PROD_W      = 40;   // byte * charge span

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    REG_TEMP_LOW     = 4'd0,
    REG_TEMP_HIGH    = 4'd1,
    REG_CURRENT_LOW  = 4'd2,
    REG_CURRENT_HIGH = 4'd3,
    REG_CHARGE_LOW   = 4'd4,
    REG_CHARGE_HIGH  = 4'd5,
    REG_ROW_COUNT    = 4'd6,
    REG_COL_COUNT    = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [PROD_W-1:0] y;   // residue still to be divided
    logic [31:0]       q;   // quotient so far, modulo 2^32
  } fold_t;

  // 256*a + b = 255*a + (a + b): one step of the divide by 255
  function automatic fold_t fold_step(input fold_t f);
    logic [PROD_W-9:0] a;
    fold_t             r;
    a   = f.y[PROD_W-1:8];
    r.q = f.q + a[31:0];
    r.y = PROD_W'(a) + PROD_W'(f.y[7:0]);
    return r;
  endfunction

endpackage

// ----- rtl/core/temp_current_charge_lookup.sv -----
// Temperature/current charge lookup: byte table with nearest-cell access.
// Throughput: one request per cycle; backpressure propagates stage by stage.
// Pipeline: 5-step restoring divider for the indices, one table read port,
// 8x32 multiplier and a folding divide by 255.
// Reset clears the registers to defaults and the pipeline; the table is not cleared.
module temp_current_charge_lookup
  import tccl_pkg::*;
#(
  parameter int unsigned ROW_MAX = ROW_MAX_DEF,
  parameter int unsigned COL_MAX = COL_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_row[3:0], cell_col[7:4], cell_value[15:8], temperature[47:16], current[79:48]
  input  logic [79:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // charge_value[31:0], row_used[35:32], col_used[39:36]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned DEPTH  = ROW_MAX * COL_MAX;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NS     = 14;
  localparam int unsigned ST_MEM = 7;
  localparam int unsigned ST_RD  = 8;
  localparam int unsigned ST_OUT = 13;

  // ---------------- configuration registers ----------------
  logic signed [31:0] lo_q [2];     // lane 0 temperature, lane 1 current
  logic signed [31:0] hi_q [2];
  logic signed [31:0] clo_q, chi_q;
  logic [CNT_W-1:0]   cnt_q [2];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q[0]  <= 32'sd0;
      hi_q[0]  <= 32'sd1;
      lo_q[1]  <= 32'sd0;
      hi_q[1]  <= 32'sd1;
      clo_q    <= 32'sd0;
      chi_q    <= 32'sd255;
      cnt_q[0] <= CNT_W'(16);
      cnt_q[1] <= CNT_W'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TEMP_LOW:     lo_q[0]  <= cfg_data_i;
        REG_TEMP_HIGH:    hi_q[0]  <= cfg_data_i;
        REG_CURRENT_LOW:  lo_q[1]  <= cfg_data_i;
        REG_CURRENT_HIGH: hi_q[1]  <= cfg_data_i;
        REG_CHARGE_LOW:   clo_q    <= cfg_data_i;
        REG_CHARGE_HIGH:  chi_q    <= cfg_data_i;
        REG_ROW_COUNT:    cnt_q[0] <= cfg_data_i[CNT_W-1:0];
        REG_COL_COUNT:    cnt_q[1] <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [CNT_W-1:0] eff_cnt(input logic [CNT_W-1:0] c,
                                               input int unsigned mx);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (32'(c) > mx) r = CNT_W'(mx);
    return r;
  endfunction

  // derived from registers; the user must keep them static while requests are in flight, the block does not enforce it
  logic [CNT_W-1:0]   cnt_eff [2];
  logic signed [32:0] span [2];
  logic [MAG_W-1:0]   span_mag [2];
  logic signed [32:0] cspan;
  logic [MAG_W-1:0]   cspan_mag;

  assign cnt_eff[0] = eff_cnt(cnt_q[0], ROW_MAX);
  assign cnt_eff[1] = eff_cnt(cnt_q[1], COL_MAX);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      span[l]     = {hi_q[l][31], hi_q[l]} - {lo_q[l][31], lo_q[l]};
      span_mag[l] = span[l][32] ? MAG_W'(-span[l]) : MAG_W'(span[l]);
    end
    cspan     = {chi_q[31], chi_q} - {clo_q[31], clo_q};
    cspan_mag = cspan[32] ? MAG_W'(-cspan) : MAG_W'(cspan);
  end

  // ---------------- pipeline flow control ----------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] ld;      // stage may load this cycle

  always_comb begin
    ld[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign s_axis_tready = ld[0];

  // ---------------- payload registers ----------------
  cmd_e               cmd_q  [0:ST_MEM];
  logic [3:0]         wrow_q [0:ST_MEM];
  logic [3:0]         wcol_q [0:ST_MEM];
  logic [7:0]         wval_q [0:ST_MEM];
  logic signed [32:0] diff_q [2];
  logic [NUM_W-1:0]   rem_q  [1:6][2];
  logic [4:0]         quo_q  [1:6][2];
  logic               zero_q [1:6][2];
  logic [CNT_W-1:0]   idx_q  [ST_MEM:ST_OUT-1][2];
  logic [7:0]         rd_q;
  fold_t              fld_q  [9:12];
  logic               neg_q  [9:12];
  logic [31:0]        charge_q;
  logic [3:0]         row_o_q, col_o_q;

  logic [7:0] mem [DEPTH];

  // stage 0 operands
  logic signed [32:0] val_in [2];
  assign val_in[0] = {s_axis_tdata[47], s_axis_tdata[47:16]};
  assign val_in[1] = {s_axis_tdata[79], s_axis_tdata[79:48]};

  // stage 1 inputs
  logic [MAG_W-1:0] dmag [2];
  logic             dzero [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dmag[l]  = diff_q[l][32] ? MAG_W'(-diff_q[l]) : MAG_W'(diff_q[l]);
      dzero[l] = (span[l] == '0) ||
                 ((diff_q[l] != '0) && (diff_q[l][32] != span[l][32]));
    end
  end

  // clamp after the last divide step
  logic [CNT_W-1:0] idx_d [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (zero_q[6][l]) idx_d[l] = '0;
      else if (CNT_W'(quo_q[6][l]) > cnt_eff[l] - CNT_W'(1)) idx_d[l] = cnt_eff[l] - CNT_W'(1);
      else idx_d[l] = CNT_W'(quo_q[6][l]);
    end
  end

  // table addresses
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  assign rd_addr = AW'(idx_q[ST_MEM][0]) * AW'(COL_MAX) + AW'(idx_q[ST_MEM][1]);
  assign wr_addr = AW'(wrow_q[ST_MEM]) * AW'(COL_MAX) + AW'(wcol_q[ST_MEM]);
  assign wr_en   = vld_q[ST_MEM] && ld[ST_RD] && (cmd_q[ST_MEM] == CMD_WRITE) &&
                   (32'(wrow_q[ST_MEM]) < ROW_MAX) && (32'(wcol_q[ST_MEM]) < COL_MAX);

  // scale and final correction
  logic [PROD_W-1:0] prod;
  logic [31:0]       q_fin;
  assign prod  = PROD_W'(rd_q) * PROD_W'(cspan_mag);
  assign q_fin = (fld_q[12].y >= PROD_W'(255)) ? fld_q[12].q + 32'd1 : fld_q[12].q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          if (k == ST_RD) vld_q[k] <= vld_q[k-1] && (cmd_q[ST_MEM] == CMD_LOOKUP);
          else vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      cmd_q[0]  <= cmd_e'(s_axis_tuser);
      wrow_q[0] <= s_axis_tdata[3:0];
      wcol_q[0] <= s_axis_tdata[7:4];
      wval_q[0] <= s_axis_tdata[15:8];
      for (int l = 0; l < 2; l++) begin
        diff_q[l] <= val_in[l] - {lo_q[l][31], lo_q[l]};
      end
    end
    for (int k = 1; k <= ST_MEM; k++) begin
      if (ld[k]) begin
        cmd_q[k]  <= cmd_q[k-1];
        wrow_q[k] <= wrow_q[k-1];
        wcol_q[k] <= wcol_q[k-1];
        wval_q[k] <= wval_q[k-1];
      end
    end
    if (ld[1]) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[1][l]  <= NUM_W'(cnt_eff[l]) * NUM_W'(dmag[l]);
        quo_q[1][l]  <= '0;
        zero_q[1][l] <= dzero[l];
      end
    end
    // one quotient bit per stage, from bit 4 down to bit 0
    for (int k = 2; k <= 6; k++) begin
      if (ld[k]) begin
        for (int l = 0; l < 2; l++) begin
          zero_q[k][l] <= zero_q[k-1][l];
          if (rem_q[k-1][l] >= (NUM_W'(span_mag[l]) << (6 - k))) begin
            rem_q[k][l] <= rem_q[k-1][l] - (NUM_W'(span_mag[l]) << (6 - k));
            quo_q[k][l] <= quo_q[k-1][l] | (5'd1 << (6 - k));
          end else begin
            rem_q[k][l] <= rem_q[k-1][l];
            quo_q[k][l] <= quo_q[k-1][l];
          end
        end
      end
    end
    if (ld[ST_MEM]) begin
      idx_q[ST_MEM] <= idx_d;
    end
    for (int k = ST_RD; k < ST_OUT; k++) begin
      if (ld[k]) idx_q[k] <= idx_q[k-1];
    end
    // table: write and read in the same stage keep request order
    if (wr_en) mem[wr_addr] <= wval_q[ST_MEM];
    if (ld[ST_RD]) rd_q <= mem[rd_addr];
    if (ld[9]) begin
      fld_q[9].y <= prod;
      fld_q[9].q <= '0;
      neg_q[9]   <= cspan[32];
    end
    for (int k = 10; k <= 12; k++) begin
      if (ld[k]) begin
        fld_q[k] <= fold_step(fold_step(fld_q[k-1]));
        neg_q[k] <= neg_q[k-1];
      end
    end
    if (ld[ST_OUT]) begin
      charge_q <= clo_q + (neg_q[12] ? -q_fin : q_fin);
      row_o_q  <= idx_q[ST_OUT-1][0][3:0];
      col_o_q  <= idx_q[ST_OUT-1][1][3:0];
    end
  end

  assign m_axis_tvalid = vld_q[ST_OUT];
  assign m_axis_tdata  = {col_o_q, row_o_q, charge_q};

  // ---------------- assertions ----------------
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_MEM] && cmd_q[ST_MEM] == CMD_LOOKUP) |->
      (idx_q[ST_MEM][0] < cnt_eff[0]) && (idx_q[ST_MEM][1] < cnt_eff[1]))
    else $error("clamped index out of range");

  a_fold_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] |-> (fld_q[12].y <= PROD_W'(256)))
    else $error("divide by 255 residue not reduced");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_MEM] && cmd_q[ST_MEM] == CMD_WRITE && ld[ST_RD]) |=> !vld_q[ST_RD])
    else $error("table write produced a result");

endmodule

// ----- sim/tb_temp_current_charge_lookup.sv -----
// Testbench for temp_current_charge_lookup: table writes and charge lookups over a
// stream interface with random gaps and stalls, checked against a behavioral predictor.
// Depends on tccl_pkg and the RTL top level.
module tb_temp_current_charge_lookup;
  import tccl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 13;
  localparam int WDOG_MAX    = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIR       = 22;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [7:0]  val;
    logic [31:0] temp;
    logic [31:0] cur;
  } req_t;

  typedef struct packed {
    logic [31:0] charge;
    logic [3:0]  row;
    logic [3:0]  col;
  } res_t;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_DRAIN
  } step_e;

  typedef struct {
    step_e       kind;
    req_t        q;
    bit          has_exp;
    res_t        exp_r;
    reg_idx_e    idx;
    logic [31:0] data;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  temp_current_charge_lookup u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  cells [16][16];
  logic [31:0] lut_reg [8];
  res_t        charge_q [$];
  int          n_err = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  function automatic longint to_idx(longint v, longint lo, longint hi, longint n);
    longint span, i;
    span = hi - lo;
    i = 0;
    if (span != 0) i = (n * (v - lo)) / span;
    if (i < 0) i = 0;
    if (i > n - 1) i = n - 1;
    return i;
  endfunction

  function automatic longint eff_cnt(logic [31:0] r);
    longint n;
    n = r[4:0];
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic res_t predict_charge(req_t q);
    res_t   r;
    longint y, x, v, clo, chi;
    y = to_idx(longint'(signed'(q.temp)), longint'(signed'(lut_reg[REG_TEMP_LOW])),
               longint'(signed'(lut_reg[REG_TEMP_HIGH])), eff_cnt(lut_reg[REG_ROW_COUNT]));
    x = to_idx(longint'(signed'(q.cur)), longint'(signed'(lut_reg[REG_CURRENT_LOW])),
               longint'(signed'(lut_reg[REG_CURRENT_HIGH])), eff_cnt(lut_reg[REG_COL_COUNT]));
    v = cells[y][x];
    clo = longint'(signed'(lut_reg[REG_CHARGE_LOW]));
    chi = longint'(signed'(lut_reg[REG_CHARGE_HIGH]));
    r.charge = 32'(clo + (v * (chi - clo)) / 255);
    r.row = 4'(y);
    r.col = 4'(x);
    return r;
  endfunction

  task automatic cfg_write(reg_idx_e idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    lut_reg[idx] = (idx >= REG_ROW_COUNT) ? {27'd0, data[4:0]} : data;
    @(negedge clk_i);
  endtask

  // tvalid stays high on return so requests can follow back to back
  task automatic send_req(req_t q, bit has_exp = 0, res_t exp_r = '0);
    res_t r;
    int   gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {q.cur, q.temp, q.val, q.col, q.row};
    s_axis_tuser  <= q.cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (q.cmd == CMD_WRITE) begin
      cells[q.row][q.col] = q.val;
    end else begin
      r = predict_charge(q);
      if (has_exp && r != exp_r) begin
        n_err++;
        if (n_err <= 10)
          $display("directed entry: exp charge %h row %0d col %0d, got charge %h row %0d col %0d",
                   exp_r.charge, exp_r.row, exp_r.col, r.charge, r.row, r.col);
      end
      charge_q.push_back(r);
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (charge_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  function automatic req_t wr(int r, int c, int v);
    req_t q;
    q = '{CMD_WRITE, 4'(r), 4'(c), 8'(v), $urandom, $urandom};
    return q;
  endfunction

  function automatic req_t lk(logic [31:0] t, logic [31:0] c);
    req_t q;
    q = '{CMD_LOOKUP, 4'($urandom), 4'($urandom), 8'($urandom), t, c};
    return q;
  endfunction

  function automatic step_t s_req(req_t q, bit has_exp = 0, res_t exp_r = '0);
    step_t s;
    s.kind    = STEP_REQ;
    s.q       = q;
    s.has_exp = has_exp;
    s.exp_r   = exp_r;
    s.idx     = REG_TEMP_LOW;
    s.data    = '0;
    return s;
  endfunction

  function automatic step_t s_cfg(reg_idx_e idx, logic [31:0] data);
    step_t s;
    s = s_req(wr(0, 0, 0));
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t s_drain();
    step_t s;
    s = s_req(wr(0, 0, 0));
    s.kind = STEP_DRAIN;
    return s;
  endfunction

  // receiver: random stalls; a hold-off request keeps it off for HOLD_CYCLES
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      else if ($urandom_range(0, 2) == 0) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 29) == 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= $urandom_range(0, 3) != 0;
    end
  end

  // checker and watchdog
  always @(posedge clk_i) begin
    res_t got, e;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || (!s_axis_tvalid && charge_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.charge = m_axis_tdata[31:0];
        got.row    = m_axis_tdata[35:32];
        got.col    = m_axis_tdata[39:36];
        if (charge_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          e = charge_q.pop_front();
          if (got != e) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp charge %h row %0d col %0d, got charge %h row %0d col %0d",
                       e.charge, e.row, e.col, got.charge, got.row, got.col);
          end
        end
      end
    end
  end

  initial begin
    req_t  q;
    step_t dir [N_DIR];
    logic [31:0] edge_v [6];
    edge_v = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1, 32'h0000_00ff};
    lut_reg = '{32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd255, 32'd16, 32'd16};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the whole table so no lookup ever reads an unwritten cell
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) send_req(wr(r, c, (r * 16 + c) ^ 8'h5a));

    // directed: defaults, extremes, zero span, negative span, count limits
    dir = '{
      s_req(wr(0, 0, 0)),
      s_req(wr(15, 15, 255)),
      s_req(lk(32'd0, 32'd0), 1, '{32'd0, 4'd0, 4'd0}),
      s_req(lk(32'h7fff_ffff, 32'h7fff_ffff), 1, '{32'd255, 4'd15, 4'd15}),
      s_req(lk(32'h8000_0000, 32'h8000_0000), 1, '{32'd0, 4'd0, 4'd0}),
      s_req(lk(32'd1, 32'hffff_ffff)),
      s_drain(),
      s_cfg(REG_CHARGE_LOW, 32'h8000_0000),
      s_cfg(REG_CHARGE_HIGH, 32'h7fff_ffff),
      s_req(lk(32'h7fff_ffff, 32'h7fff_ffff), 1, '{32'h7fff_ffff, 4'd15, 4'd15}),
      s_req(lk(32'h8000_0000, 32'h8000_0000), 1, '{32'h8000_0000, 4'd0, 4'd0}),
      s_drain(),
      s_cfg(REG_TEMP_LOW, 32'd5),
      s_cfg(REG_TEMP_HIGH, 32'd5),              // zero span
      s_cfg(REG_CURRENT_LOW, 32'h7fff_ffff),
      s_cfg(REG_CURRENT_HIGH, 32'h8000_0000),   // negative span
      s_cfg(REG_ROW_COUNT, 32'd0),              // count zero -> one
      s_cfg(REG_COL_COUNT, 32'd31),             // count above max
      s_req(lk(32'd9, 32'd0)),
      s_req(lk(32'h8000_0000, 32'h7fff_ffff)),
      s_req(lk(32'h7fff_ffff, 32'h8000_0000)),
      s_drain()
    };
    foreach (dir[i]) begin
      unique case (dir[i].kind)
        STEP_REQ:   send_req(dir[i].q, dir[i].has_exp, dir[i].exp_r);
        STEP_CFG:   cfg_write(dir[i].idx, dir[i].data);
        STEP_DRAIN: drain();
        default: ;
      endcase
    end

    // random phases with varying settings; one phase holds the receiver off
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 8; i++) begin
        logic [31:0] d;
        d = ($urandom_range(0, 2) == 0) ? edge_v[$urandom_range(0, 5)] : $urandom;
        if (i < 6 && $urandom_range(0, 1)) d = 32'(signed'($urandom_range(0, 400)) - 200);
        if (i >= 6) d = $urandom_range(0, 31);
        if (ph == 9) d = (i == 6 || i == 7) ? 32'd16 : d;
        cfg_write(reg_idx_e'(i), d);
      end
      if (ph == 3) hold_off = 1'b1;
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 4) == 0)
          q = wr($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
        else if ($urandom_range(0, 1))
          q = lk(32'(signed'($urandom_range(0, 600)) - 300),
                 32'(signed'($urandom_range(0, 600)) - 300));
        else
          q = lk(($urandom_range(0, 5) == 0) ? edge_v[$urandom_range(0, 5)] : $urandom,
                 ($urandom_range(0, 5) == 0) ? edge_v[$urandom_range(0, 5)] : $urandom);
        send_req(q);
      end
      drain();
    end
    if (n_err == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
